@@ src/sjf_pkg.sv @@
// shared types and constants for the shortest-job-first scheduler
package sjf_pkg;

   // fixed widths of the result fields
   localparam int JOB_ID_W    = 4;
   localparam int JOB_BURST_W = 16;
   localparam int WAIT_W      = 20;
   localparam int AVG_W       = 28;
   localparam int FRAC_BITS   = 8;

   // sequencer states, one-hot
   typedef enum logic [12:0] {
      ST_LOAD = 13'h0001,
      ST_RDI  = 13'h0002,
      ST_LDI  = 13'h0004,
      ST_CMP  = 13'h0008,
      ST_WRI  = 13'h0010,
      ST_SUMA = 13'h0020,
      ST_SUM  = 13'h0040,
      ST_DWS  = 13'h0080,
      ST_DWW  = 13'h0100,
      ST_DTS  = 13'h0200,
      ST_DTW  = 13'h0400,
      ST_OUTA = 13'h0800,
      ST_OUT  = 13'h1000
   } state_type;

endpackage

@@ src/sjf_ram.sv @@
// generic single-write, single-read ram with registered read data
module sjf_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sjf_div.sv @@
// restoring divider, one quotient bit per cycle
module sjf_div #(
   parameter int DVW = 34,
   parameter int DSW = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [DVW-1:0] quotient
);

   localparam int CW = $clog2(DVW + 1);

   logic [DSW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] quo_ff, quo_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DSW:0]   rem_sh;
   logic           ge;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff, quo_ff[DVW-1]};
   assign ge     = (rem_sh >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(DVW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = DSW'(rem_sh - {1'b0, divisor});
         end else begin
            rem_in = rem_sh[DSW-1:0];
         end
         quo_in = {quo_ff[DVW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // remainder stays below the divisor while dividing
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, rem_ff} < {1'b0, divisor}))
      else $error("divider remainder out of range");

   // no restart while a division runs
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("divider restarted while busy");

   // done follows the last step
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

endmodule

@@ src/shortest_job_first_scheduler_core.sv @@
// shortest-job-first scheduler: load, exchange sort, averages, result stream
// operation: one item per cycle while loading; after the closing item an exchange sort runs with
//   one compare per cycle on the table ram port, then the sums, then two divisions, then
//   n results back to back, the first issued through ST_OUTA and ST_OUT and its output registers
//   after the second division reports done
// throughput: a new set is accepted only after the final result of the last set; no stalls
// reset: synchronous, active high; empties the job table count and idles the sequencer
module shortest_job_first_scheduler_core #(
   parameter int MAX_JOBS   = 16,
   parameter int BURST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_burst,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [3:0]  rsp_job_id,
   output logic [15:0] rsp_job_burst,
   output logic [19:0] rsp_wait_time,
   output logic [19:0] rsp_turnaround,
   output logic [27:0] rsp_avg_wait_q8,
   output logic [27:0] rsp_avg_turnaround_q8,
   output logic        rsp_final_res
);

   localparam int BW    = (BURST_BITS < sjf_pkg::JOB_BURST_W) ? BURST_BITS
                                                              : sjf_pkg::JOB_BURST_W;
   localparam int IDW   = $clog2(MAX_JOBS);
   localparam int CNTW  = $clog2(MAX_JOBS + 1);
   localparam int WAITW = BW + CNTW;
   localparam int SUMW  = BW + 2 * CNTW;
   localparam int DVW   = SUMW + sjf_pkg::FRAC_BITS;
   localparam int RW    = IDW + BW;

   sjf_pkg::state_type state_ff, state_in;

   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [CNTW-1:0]  n_ff, n_in;
   logic [CNTW-1:0]  i_ff, i_in;
   logic [CNTW-1:0]  k_ff, k_in;
   logic [RW-1:0]    cur_ff, cur_in;
   logic [WAITW-1:0] wait_ff, wait_in;
   logic [SUMW-1:0]  sum_w_ff, sum_w_in;
   logic [SUMW-1:0]  sum_t_ff, sum_t_in;
   logic [sjf_pkg::AVG_W-1:0] avg_w_ff, avg_w_in;
   logic [sjf_pkg::AVG_W-1:0] avg_t_ff, avg_t_in;

   logic        valid_ff, valid_in;
   logic [3:0]  id_o_ff, id_o_in;
   logic [15:0] burst_o_ff, burst_o_in;
   logic [19:0] wait_o_ff, wait_o_in;
   logic [19:0] tat_o_ff, tat_o_in;
   logic        final_o_ff, final_o_in;

   logic            wr_en;
   logic [IDW-1:0]  wr_addr;
   logic [RW-1:0]   wr_data;
   logic [IDW-1:0]  rd_addr;
   logic [RW-1:0]   rd_data;
   logic [BW-1:0]   rd_burst;
   logic [IDW-1:0]  rd_id;
   logic [BW-1:0]   cur_burst;

   logic            div_start;
   logic [DVW-1:0]  div_dividend;
   logic            div_done;
   logic [DVW-1:0]  div_quotient;

   logic            accept;
   logic [CNTW-1:0] cnt_nx;
   logic [WAITW-1:0] tat;
   logic [IDW+3:0]   id_x;
   logic [BW+15:0]   burst_x;
   logic [WAITW+19:0] wait_x;
   logic [WAITW+19:0] tat_x;
   logic [DVW+27:0]   quo_x;

   // job table: {arrival id, burst}
   sjf_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared divider for both averages
   sjf_div #(
      .DVW (DVW),
      .DSW (CNTW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign accept    = start && !busy;
   assign cnt_nx    = cnt_ff + CNTW'(1);
   assign rd_burst  = rd_data[BW-1:0];
   assign rd_id     = rd_data[RW-1:BW];
   assign cur_burst = cur_ff[BW-1:0];
   assign tat       = wait_ff + WAITW'(rd_burst);

   // field extension and wrap to the result widths
   assign id_x    = {{sjf_pkg::JOB_ID_W{1'b0}}, rd_id};
   assign burst_x = {{sjf_pkg::JOB_BURST_W{1'b0}}, rd_burst};
   assign wait_x  = {{sjf_pkg::WAIT_W{1'b0}}, wait_ff};
   assign tat_x   = {{sjf_pkg::WAIT_W{1'b0}}, tat};
   assign quo_x   = {{sjf_pkg::AVG_W{1'b0}}, div_quotient};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      wait_in      = wait_ff;
      sum_w_in     = sum_w_ff;
      sum_t_in     = sum_t_ff;
      avg_w_in     = avg_w_ff;
      avg_t_in     = avg_t_ff;
      valid_in     = 1'b0;
      id_o_in      = id_o_ff;
      burst_o_in   = burst_o_ff;
      wait_o_in    = wait_o_ff;
      tat_o_in     = tat_o_ff;
      final_o_in   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IDW-1:0];
      wr_data      = {cnt_ff[IDW-1:0], req_burst[BW-1:0]};
      rd_addr      = i_ff[IDW-1:0];
      div_start    = 1'b0;
      div_dividend = {sum_w_ff, {sjf_pkg::FRAC_BITS{1'b0}}};
      case (state_ff)
         // store jobs; the last or table-filling item closes the set
         sjf_pkg::ST_LOAD: begin
            if (accept) begin
               wr_en = 1'b1;
               if (req_last || (cnt_nx == CNTW'(MAX_JOBS))) begin
                  n_in   = cnt_nx;
                  cnt_in = '0;
                  i_in   = '0;
                  if (cnt_nx == CNTW'(1)) begin
                     state_in = sjf_pkg::ST_SUMA;
                  end else begin
                     state_in = sjf_pkg::ST_RDI;
                  end
               end else begin
                  cnt_in = cnt_nx;
               end
            end
         end
         // fetch entry i as the running candidate
         sjf_pkg::ST_RDI: begin
            rd_addr  = i_ff[IDW-1:0];
            k_in     = i_ff + CNTW'(1);
            state_in = sjf_pkg::ST_LDI;
         end
         sjf_pkg::ST_LDI: begin
            cur_in   = rd_data;
            rd_addr  = k_ff[IDW-1:0];
            state_in = sjf_pkg::ST_CMP;
         end
         // compare candidate with entry k, swap when candidate is longer
         sjf_pkg::ST_CMP: begin
            if (cur_burst > rd_burst) begin
               wr_en   = 1'b1;
               wr_addr = k_ff[IDW-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            if (k_ff + CNTW'(1) == n_ff) begin
               state_in = sjf_pkg::ST_WRI;
            end else begin
               k_in    = k_ff + CNTW'(1);
               rd_addr = k_in[IDW-1:0];
            end
         end
         // put the candidate back at position i
         sjf_pkg::ST_WRI: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[IDW-1:0];
            wr_data = cur_ff;
            i_in    = i_ff + CNTW'(1);
            if (i_ff + CNTW'(2) == n_ff) begin
               state_in = sjf_pkg::ST_SUMA;
            end else begin
               state_in = sjf_pkg::ST_RDI;
            end
         end
         // accumulate waiting and turnaround sums
         sjf_pkg::ST_SUMA: begin
            rd_addr  = '0;
            i_in     = '0;
            wait_in  = '0;
            sum_w_in = '0;
            sum_t_in = '0;
            state_in = sjf_pkg::ST_SUM;
         end
         sjf_pkg::ST_SUM: begin
            wait_in  = tat;
            sum_w_in = sum_w_ff + SUMW'(wait_ff);
            sum_t_in = sum_t_ff + SUMW'(tat);
            if (i_ff + CNTW'(1) == n_ff) begin
               state_in = sjf_pkg::ST_DWS;
            end else begin
               i_in    = i_ff + CNTW'(1);
               rd_addr = i_in[IDW-1:0];
            end
         end
         // average waiting time
         sjf_pkg::ST_DWS: begin
            div_start    = 1'b1;
            div_dividend = {sum_w_ff, {sjf_pkg::FRAC_BITS{1'b0}}};
            state_in     = sjf_pkg::ST_DWW;
         end
         sjf_pkg::ST_DWW: begin
            if (div_done) begin
               avg_w_in = quo_x[sjf_pkg::AVG_W-1:0];
               state_in = sjf_pkg::ST_DTS;
            end
         end
         // average turnaround time
         sjf_pkg::ST_DTS: begin
            div_start    = 1'b1;
            div_dividend = {sum_t_ff, {sjf_pkg::FRAC_BITS{1'b0}}};
            state_in     = sjf_pkg::ST_DTW;
         end
         sjf_pkg::ST_DTW: begin
            if (div_done) begin
               avg_t_in = quo_x[sjf_pkg::AVG_W-1:0];
               state_in = sjf_pkg::ST_OUTA;
            end
         end
         // stream one result per job in schedule order
         sjf_pkg::ST_OUTA: begin
            rd_addr  = '0;
            i_in     = '0;
            wait_in  = '0;
            state_in = sjf_pkg::ST_OUT;
         end
         sjf_pkg::ST_OUT: begin
            valid_in   = 1'b1;
            id_o_in    = id_x[sjf_pkg::JOB_ID_W-1:0];
            burst_o_in = burst_x[sjf_pkg::JOB_BURST_W-1:0];
            wait_o_in  = wait_x[sjf_pkg::WAIT_W-1:0];
            tat_o_in   = tat_x[sjf_pkg::WAIT_W-1:0];
            wait_in    = tat;
            if (i_ff + CNTW'(1) == n_ff) begin
               final_o_in = 1'b1;
               state_in   = sjf_pkg::ST_LOAD;
            end else begin
               i_in    = i_ff + CNTW'(1);
               rd_addr = i_in[IDW-1:0];
            end
         end
         default: begin
            state_in = sjf_pkg::ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sjf_pkg::ST_LOAD;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      cur_ff     <= cur_in;
      wait_ff    <= wait_in;
      sum_w_ff   <= sum_w_in;
      sum_t_ff   <= sum_t_in;
      avg_w_ff   <= avg_w_in;
      avg_t_ff   <= avg_t_in;
      id_o_ff    <= id_o_in;
      burst_o_ff <= burst_o_in;
      wait_o_ff  <= wait_o_in;
      tat_o_ff   <= tat_o_in;
      final_o_ff <= final_o_in;
   end

   assign busy                  = (state_ff != sjf_pkg::ST_LOAD);
   assign rsp_valid             = valid_ff;
   assign rsp_job_id            = id_o_ff;
   assign rsp_job_burst         = burst_o_ff;
   assign rsp_wait_time         = wait_o_ff;
   assign rsp_turnaround        = tat_o_ff;
   assign rsp_avg_wait_q8       = avg_w_ff;
   assign rsp_avg_turnaround_q8 = avg_t_ff;
   assign rsp_final_res         = final_o_ff;

   // fill count never reaches the table depth between sets
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNTW'(MAX_JOBS))
      else $error("job count overflow");

   // inner sort index stays inside the set
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sjf_pkg::ST_CMP) |-> (k_ff < n_ff) && (i_ff < k_ff))
      else $error("sort index out of range");

   // the final result ends the stream
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |=> !rsp_valid)
      else $error("result after final result");

   // results only come while streaming
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> (state_ff == sjf_pkg::ST_OUT))
      else $error("result outside stream phase");

endmodule
